[rtl/core/button_debounce_long_press_repeat_macros.svh]
// Assertion macros shared by the checker of the button qualifier.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BDLPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BDLPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bdlpr_pkg.sv]
// Package with the constants and types of the button qualifier.
`timescale 1ns / 1ps

package bdlpr_pkg;

	// Default widths of the elapsed timers and the pending press counter.
	localparam int TIME_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 8;

	// Width of the timing registers and of the reported press count.
	localparam int CFG_W         = 16;
	localparam int PRESS_COUNT_W = 8;
	localparam int CFG_INDEX_W   = 3;

	// Register values after reset.
	localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST        = 16'd30;
	localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST      = 16'd800;
	localparam logic [CFG_W-1:0] REPEAT_DELAY_MS_RST    = 16'd750;
	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_MS_RST = 16'd150;
	localparam logic             AUTO_REPEAT_ON_RST     = 1'b0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DEBOUNCE_MS        = 3'd0,
		CFG_LONG_PRESS_MS      = 3'd1,
		CFG_REPEAT_DELAY_MS    = 3'd2,
		CFG_REPEAT_INTERVAL_MS = 3'd3,
		CFG_AUTO_REPEAT_ON     = 3'd4
	} cfg_index_t;

endpackage

[rtl/core/button_debounce_long_press_repeat.sv]
// Debounce, long-press and auto-repeat qualifier for one active-low button.
// Each accepted request is one millisecond tick: raw_level is the pin sample
// (0 = pressed) and take_events asks for the pending events to be returned
// and cleared. Every request gives exactly one result with the debounced
// level, the pending press count, long and short press flags (nonzero only
// on a take) and step_fast, which tells whether the latest press came from
// auto-repeat.
// The input channel (in_valid/in_stall) feeds an input register; the tick
// update runs between that register and the result register, so each
// request passes through both registers before its result is valid. One
// request is taken per cycle; throughput is limited only by the receiver.
// When out_stall holds the result register, the input register still takes
// one more request; after that in_stall rises until the result is taken.
// Configuration writes (cfg_valid/cfg_ready) are always ready and must be
// made while no request is in flight. Reset clears the pipeline, returns the
// button state to released and loads the default timing registers.
`timescale 1ns / 1ps

module button_debounce_long_press_repeat #(
	parameter int TIME_BITS  = bdlpr_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS = bdlpr_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 raw_level,
	input  logic                                 take_events,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 stable_level,
	output logic [bdlpr_pkg::PRESS_COUNT_W-1:0]  press_count,
	output logic                                 long_press,
	output logic                                 short_press,
	output logic                                 step_fast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bdlpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bdlpr_pkg::CFG_W-1:0]          cfg_data
);

	localparam int CMP_W = (TIME_BITS > bdlpr_pkg::CFG_W) ? TIME_BITS : bdlpr_pkg::CFG_W;
	localparam int CNT_W = (COUNT_BITS > bdlpr_pkg::PRESS_COUNT_W) ?
		COUNT_BITS : bdlpr_pkg::PRESS_COUNT_W;
	localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CNT_W-1:0] OUT_MAX =
		CNT_W'({bdlpr_pkg::PRESS_COUNT_W{1'b1}});

	// Timing registers.
	logic [bdlpr_pkg::CFG_W-1:0] debounce_ms_q;
	logic [bdlpr_pkg::CFG_W-1:0] long_press_ms_q;
	logic [bdlpr_pkg::CFG_W-1:0] repeat_delay_ms_q;
	logic [bdlpr_pkg::CFG_W-1:0] repeat_interval_ms_q;
	logic                        auto_repeat_on_q;

	// Button state.
	logic                  last_sample_q;
	logic                  debounced_q;
	logic [TIME_BITS-1:0]  since_change_q;
	logic [TIME_BITS-1:0]  held_time_q;
	logic [TIME_BITS-1:0]  since_repeat_q;
	logic [COUNT_BITS-1:0] pending_q;
	logic                  long_fired_q;
	logic                  long_pending_q;
	logic                  short_pending_q;
	logic                  fast_flag_q;

	// Input register and result register.
	logic valid_s1;
	logic raw_s1;
	logic take_s1;
	logic valid_s2;
	logic stable_s2;
	logic [bdlpr_pkg::PRESS_COUNT_W-1:0] count_s2;
	logic long_s2;
	logic short_s2;
	logic fast_s2;

	logic advance;

	// Next state of one tick.
	logic [TIME_BITS-1:0]  sc_n;
	logic [TIME_BITS-1:0]  held_n;
	logic [TIME_BITS-1:0]  srep_mid;
	logic [TIME_BITS-1:0]  srep_n;
	logic [COUNT_BITS-1:0] pend_mid;
	logic [COUNT_BITS-1:0] pend_n;
	logic                  deb_n;
	logic                  accept_chg;
	logic                  press_edge;
	logic                  release_edge;
	logic                  lf_mid;
	logic                  lf_n;
	logic                  repeat_hit;
	logic                  long_hit;
	logic                  long_pend_n;
	logic                  short_pend_n;
	logic                  fast_n;
	logic [CNT_W-1:0]      pend_ext;
	logic [bdlpr_pkg::PRESS_COUNT_W-1:0] count_out;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	assign out_valid    = valid_s2;
	assign stable_level = stable_s2;
	assign press_count  = count_s2;
	assign long_press   = long_s2;
	assign short_press  = short_s2;
	assign step_fast    = fast_s2;

	always_comb begin
		// The change timer restarts whenever the raw level moves.
		if (raw_s1 != last_sample_q) begin
			sc_n = '0;
		end else if (since_change_q == TIME_MAX) begin
			sc_n = TIME_MAX;
		end else begin
			sc_n = since_change_q + TIME_BITS'(1);
		end

		accept_chg   = (CMP_W'(sc_n) > CMP_W'(debounce_ms_q)) && (raw_s1 != debounced_q);
		press_edge   = accept_chg && !raw_s1;
		release_edge = accept_chg && raw_s1;
		deb_n        = accept_chg ? raw_s1 : debounced_q;

		if (press_edge) begin
			held_n   = '0;
			srep_mid = '0;
		end else begin
			held_n   = (held_time_q == TIME_MAX) ? TIME_MAX : held_time_q + TIME_BITS'(1);
			srep_mid = (since_repeat_q == TIME_MAX) ?
				TIME_MAX : since_repeat_q + TIME_BITS'(1);
		end

		lf_mid   = press_edge ? 1'b0 : long_fired_q;
		pend_mid = (press_edge && pending_q != COUNT_MAX) ?
			pending_q + COUNT_BITS'(1) : pending_q;

		repeat_hit = auto_repeat_on_q && !raw_s1 &&
			(CMP_W'(held_n) >= CMP_W'(repeat_delay_ms_q)) &&
			(CMP_W'(srep_mid) >= CMP_W'(repeat_interval_ms_q));
		pend_n = (repeat_hit && pend_mid != COUNT_MAX) ? pend_mid + COUNT_BITS'(1) : pend_mid;
		srep_n = repeat_hit ? '0 : srep_mid;

		if (repeat_hit) begin
			fast_n = 1'b1;
		end else if (press_edge) begin
			fast_n = 1'b0;
		end else begin
			fast_n = fast_flag_q;
		end

		long_hit = !lf_mid && !deb_n && !raw_s1 &&
			(CMP_W'(held_n) >= CMP_W'(long_press_ms_q));
		lf_n         = lf_mid || long_hit;
		long_pend_n  = long_pending_q || long_hit;
		short_pend_n = short_pending_q || (release_edge && !long_fired_q);

		pend_ext  = CNT_W'(pend_n);
		count_out = (pend_ext > OUT_MAX) ? bdlpr_pkg::PRESS_COUNT_W'(OUT_MAX) :
			bdlpr_pkg::PRESS_COUNT_W'(pend_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q        <= bdlpr_pkg::DEBOUNCE_MS_RST;
			long_press_ms_q      <= bdlpr_pkg::LONG_PRESS_MS_RST;
			repeat_delay_ms_q    <= bdlpr_pkg::REPEAT_DELAY_MS_RST;
			repeat_interval_ms_q <= bdlpr_pkg::REPEAT_INTERVAL_MS_RST;
			auto_repeat_on_q     <= bdlpr_pkg::AUTO_REPEAT_ON_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdlpr_pkg::CFG_DEBOUNCE_MS:        debounce_ms_q        <= cfg_data;
				bdlpr_pkg::CFG_LONG_PRESS_MS:      long_press_ms_q      <= cfg_data;
				bdlpr_pkg::CFG_REPEAT_DELAY_MS:    repeat_delay_ms_q    <= cfg_data;
				bdlpr_pkg::CFG_REPEAT_INTERVAL_MS: repeat_interval_ms_q <= cfg_data;
				bdlpr_pkg::CFG_AUTO_REPEAT_ON:     auto_repeat_on_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			raw_s1  <= raw_level;
			take_s1 <= take_events;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q   <= 1'b1;
			debounced_q     <= 1'b1;
			since_change_q  <= '0;
			held_time_q     <= '0;
			since_repeat_q  <= '0;
			pending_q       <= '0;
			long_fired_q    <= 1'b0;
			long_pending_q  <= 1'b0;
			short_pending_q <= 1'b0;
			fast_flag_q     <= 1'b0;
		end else if (advance) begin
			last_sample_q   <= raw_s1;
			debounced_q     <= deb_n;
			since_change_q  <= sc_n;
			held_time_q     <= held_n;
			since_repeat_q  <= srep_n;
			long_fired_q    <= lf_n;
			fast_flag_q     <= fast_n;
			// A take hands the pending events to the result and clears them.
			pending_q       <= take_s1 ? '0 : pend_n;
			long_pending_q  <= take_s1 ? 1'b0 : long_pend_n;
			short_pending_q <= take_s1 ? 1'b0 : short_pend_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stable_s2 <= deb_n;
			fast_s2   <= fast_n;
			count_s2  <= take_s1 ? count_out : '0;
			long_s2   <= take_s1 && long_pend_n;
			short_s2  <= take_s1 && short_pend_n;
		end
	end

endmodule

[rtl/core/bdlpr_checker.sv]
// Port-level checker for the button qualifier and its bind statement.
`timescale 1ns / 1ps
`include "button_debounce_long_press_repeat_macros.svh"

module bdlpr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                stable_level,
	input logic [bdlpr_pkg::PRESS_COUNT_W-1:0] press_count,
	input logic                                long_press,
	input logic                                short_press,
	input logic                                step_fast
);

	// The input side only backs up behind a held result.
	`BDLPR_ASSERT_IMPL(a_stall_needs_held_result, clk, arst_n, in_stall, out_valid && out_stall, "input stalled while no result is held")

	// A result that appears from an empty output came from an accepted request that passed through the input register.
	`BDLPR_ASSERT_IMPL(a_result_from_request, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without a matching request")

	// A stalled result keeps its payload.
	`BDLPR_ASSERT_NEXT(a_stalled_result_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(press_count) && $stable(stable_level) && $stable(long_press) && $stable(short_press) && $stable(step_fast), "stalled result changed")

endmodule

bind button_debounce_long_press_repeat bdlpr_checker u_bdlpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.stable_level (stable_level),
	.press_count  (press_count),
	.long_press   (long_press),
	.short_press  (short_press),
	.step_fast    (step_fast)
);

[bench/bdlpr_bench_pkg.sv]
// Scoreboard for the button qualifier: tick-by-tick predictor and result queue.
`timescale 1ns / 1ps

package bdlpr_bench_pkg;

	typedef struct packed {
		logic                                stable;
		logic [bdlpr_pkg::PRESS_COUNT_W-1:0] presses;
		logic                                long_p;
		logic                                short_p;
		logic                                fast;
	} tick_result_t;

	typedef bit [bdlpr_pkg::TIME_BITS_DEF-1:0] time_val_t;

	class button_tick_scoreboard;
		bit [bdlpr_pkg::CFG_W-1:0] debounce_ms;
		bit [bdlpr_pkg::CFG_W-1:0] long_press_ms;
		bit [bdlpr_pkg::CFG_W-1:0] repeat_delay_ms;
		bit [bdlpr_pkg::CFG_W-1:0] repeat_interval_ms;
		bit                        auto_repeat_on;

		bit                                 last_raw;
		bit                                 level;
		time_val_t                          since_change;
		time_val_t                          held_ms;
		time_val_t                          since_repeat;
		bit [bdlpr_pkg::COUNT_BITS_DEF-1:0] presses;
		bit                                 long_fired;
		bit                                 long_pend;
		bit                                 short_pend;
		bit                                 fast;

		tick_result_t expected_q[$];
		int           checked;
		int           errors;

		function new();
			debounce_ms        = bdlpr_pkg::DEBOUNCE_MS_RST;
			long_press_ms      = bdlpr_pkg::LONG_PRESS_MS_RST;
			repeat_delay_ms    = bdlpr_pkg::REPEAT_DELAY_MS_RST;
			repeat_interval_ms = bdlpr_pkg::REPEAT_INTERVAL_MS_RST;
			auto_repeat_on     = bdlpr_pkg::AUTO_REPEAT_ON_RST;
			last_raw     = 1'b1;
			level        = 1'b1;
			since_change = '0;
			held_ms      = '0;
			since_repeat = '0;
			presses      = '0;
			long_fired   = 1'b0;
			long_pend    = 1'b0;
			short_pend   = 1'b0;
			fast         = 1'b0;
			checked      = 0;
			errors       = 0;
		endfunction

		function void write_reg(logic [bdlpr_pkg::CFG_INDEX_W-1:0] index,
		                        logic [bdlpr_pkg::CFG_W-1:0] data);
			case (index)
				bdlpr_pkg::CFG_DEBOUNCE_MS:        debounce_ms = data;
				bdlpr_pkg::CFG_LONG_PRESS_MS:      long_press_ms = data;
				bdlpr_pkg::CFG_REPEAT_DELAY_MS:    repeat_delay_ms = data;
				bdlpr_pkg::CFG_REPEAT_INTERVAL_MS: repeat_interval_ms = data;
				bdlpr_pkg::CFG_AUTO_REPEAT_ON:     auto_repeat_on = data[0];
				default: ;
			endcase
		endfunction

		function time_val_t tick_up(time_val_t t);
			return (t == '1) ? t : t + time_val_t'(1);
		endfunction

		function void count_press();
			if (presses != '1)
				presses++;
		endfunction

		function int waiting();
			return expected_q.size();
		endfunction

		// Advances the button state by one tick and queues the result it gives.
		function void note_request(bit raw, bit take);
			tick_result_t r;
			since_change = tick_up(since_change);
			held_ms      = tick_up(held_ms);
			since_repeat = tick_up(since_repeat);
			if (raw != last_raw) begin
				last_raw     = raw;
				since_change = '0;
			end
			if (since_change > debounce_ms && raw != level) begin
				level = raw;
				if (!level) begin
					count_press();
					fast         = 1'b0;
					held_ms      = '0;
					since_repeat = '0;
					long_fired   = 1'b0;
				end else if (!long_fired) begin
					short_pend = 1'b1;
				end
			end
			// Auto-repeat follows the raw pin, not the debounced level.
			if (auto_repeat_on && !raw && held_ms >= repeat_delay_ms &&
			    since_repeat >= repeat_interval_ms) begin
				count_press();
				fast         = 1'b1;
				since_repeat = '0;
			end
			if (!long_fired && !level && !raw && held_ms >= long_press_ms) begin
				long_pend  = 1'b1;
				long_fired = 1'b1;
			end
			r        = '0;
			r.stable = level;
			r.fast   = fast;
			if (take) begin
				r.presses  = presses;
				r.long_p   = long_pend;
				r.short_p  = short_pend;
				presses    = '0;
				long_pend  = 1'b0;
				short_pend = 1'b0;
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display({"ERROR: result with no request outstanding: ",
					          "level=%b presses=%0d long=%b short=%b fast=%b"},
					         got.stable, got.presses, got.long_p, got.short_p, got.fast);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.stable !== want.stable || got.presses !== want.presses ||
			    got.long_p !== want.long_p || got.short_p !== want.short_p ||
			    got.fast !== want.fast) begin
				errors++;
				if (errors <= 10)
					$display({"ERROR: result %0d expected level=%b presses=%0d long=%b ",
					          "short=%b fast=%b, got level=%b presses=%0d long=%b ",
					          "short=%b fast=%b"},
					         checked, want.stable, want.presses, want.long_p, want.short_p,
					         want.fast, got.stable, got.presses, got.long_p, got.short_p,
					         got.fast);
			end
		endfunction
	endclass

endpackage

[bench/button_debounce_long_press_repeat_test.sv]
// Top-level testbench of the button qualifier: stimulus, idling, checking and verdict.
`timescale 1ns / 1ps

module button_debounce_long_press_repeat_test;

	typedef logic [bdlpr_pkg::CFG_W-1:0] cfg_word_t;

	localparam logic [bdlpr_pkg::CFG_INDEX_W-1:0] CFG_INDEX_SPARE_FIRST = 3'd5;
	localparam logic [bdlpr_pkg::CFG_INDEX_W-1:0] CFG_INDEX_SPARE_LAST  = 3'd7;
	localparam int  QUIET_LIMIT   = 2000;
	localparam int  SETTLE_CYCLES = 8;
	localparam int  TAKE_PCT      = 15;
	localparam bit  PRESSED       = 1'b0;
	localparam bit  RELEASED      = 1'b1;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic                                raw_level = 1'b1;
	logic                                take_events = 1'b0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic                                stable_level;
	logic [bdlpr_pkg::PRESS_COUNT_W-1:0] press_count;
	logic                                long_press;
	logic                                short_press;
	logic                                step_fast;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [bdlpr_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
	cfg_word_t                           cfg_data = '0;

	bdlpr_bench_pkg::button_tick_scoreboard board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int ticks_sent = 0;
	int reg_writes = 0;
	int phases = 0;
	int quiet_cycles = 0;
	int deb_now = 30;
	int long_now = 800;
	int delay_now = 750;
	int interval_now = 150;

	button_debounce_long_press_repeat u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.raw_level    (raw_level),
		.take_events  (take_events),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.stable_level (stable_level),
		.press_count  (press_count),
		.long_press   (long_press),
		.short_press  (short_press),
		.step_fast    (step_fast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result checking and the watchdog on handshake activity.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(bdlpr_bench_pkg::tick_result_t'({stable_level,
				                   press_count, long_press, short_press, step_fast}));
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic bit pick_take();
		return ($urandom_range(99) < TAKE_PCT);
	endfunction

	// Trims a segment length so that a sequence stops at its tick target.
	function automatic int clip(int target, int n);
		return (target - ticks_sent < n) ? target - ticks_sent : n;
	endfunction

	task automatic send_tick(bit raw, bit take);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		raw_level   <= raw;
		take_events <= take;
		do @(posedge clk); while (in_stall);
		board.note_request(raw, take);
		ticks_sent++;
	endtask

	task automatic hold_level(bit raw, int n);
		repeat (n) send_tick(raw, pick_take());
	endtask

	task automatic bounce(int n);
		repeat (n) send_tick(1'($urandom_range(1)), pick_take());
	endtask

	// Mostly whole presses with random bounce and hold lengths, some pure noise.
	task automatic press_sequences(int n);
		int target;
		int reach;
		int hold_max;
		target = ticks_sent + n;
		reach = (long_now > delay_now + 4 * interval_now) ? long_now
		                                                 : delay_now + 4 * interval_now;
		hold_max = (reach + deb_now + 6 > 120) ? 120 : reach + deb_now + 6;
		while (ticks_sent < target) begin
			if ($urandom_range(99) < 85) begin
				bounce(clip(target, int'($urandom_range(0, 3))));
				hold_level(PRESSED, clip(target, int'($urandom_range(1, hold_max))));
				bounce(clip(target, int'($urandom_range(0, 3))));
				hold_level(RELEASED, clip(target,
				           int'($urandom_range(1, (deb_now > 20 ? 20 : deb_now) + 12))));
			end else begin
				bounce(clip(target, int'($urandom_range(1, 12))));
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [bdlpr_pkg::CFG_INDEX_W-1:0] index, cfg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(index, data);
		reg_writes++;
	endtask

	task automatic setup_phase(idle_mode_t mode, cfg_word_t deb, cfg_word_t lp,
	                           cfg_word_t rd, cfg_word_t ri,
	                           cfg_word_t auto_data, bit spare);
		settle();
		// Writes beyond the register list must leave every register untouched.
		if (spare) begin
			write_reg(CFG_INDEX_SPARE_FIRST, 16'hFFFF);
			write_reg(CFG_INDEX_SPARE_LAST, 16'hFFFF);
		end
		write_reg(bdlpr_pkg::CFG_DEBOUNCE_MS, deb);
		write_reg(bdlpr_pkg::CFG_LONG_PRESS_MS, lp);
		write_reg(bdlpr_pkg::CFG_REPEAT_DELAY_MS, rd);
		write_reg(bdlpr_pkg::CFG_REPEAT_INTERVAL_MS, ri);
		write_reg(bdlpr_pkg::CFG_AUTO_REPEAT_ON, auto_data);
		cfg_valid <= 1'b0;
		deb_now      = int'(deb);
		long_now     = int'(lp);
		delay_now    = int'(rd);
		interval_now = int'(ri);
		send_idle_pct  = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 24 : 0;
		recv_stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 24 : 0;
		phases++;
	endtask

	initial begin
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: a take with nothing pending and a bounce too short to count.
		send_tick(RELEASED, 1'b1);
		send_tick(PRESSED, 1'b0);
		send_tick(PRESSED, 1'b0);
		send_tick(RELEASED, 1'b0);
		send_tick(RELEASED, 1'b1);

		// All thresholds zero: press, repeat and long press land on the same tick.
		setup_phase(IDLE_NONE, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0003, 1'b1);
		send_tick(PRESSED, 1'b0);
		send_tick(PRESSED, 1'b1);
		send_tick(PRESSED, 1'b1);
		send_tick(RELEASED, 1'b0);
		send_tick(RELEASED, 1'b1);
		send_tick(RELEASED, 1'b1);

		// Release before the long press fires gives a short press; upper data bits dropped.
		setup_phase(IDLE_NONE, 16'd0, 16'd3, 16'd0, 16'd0, 16'hFFFE, 1'b0);
		send_tick(PRESSED, 1'b0);
		send_tick(PRESSED, 1'b0);
		send_tick(RELEASED, 1'b0);
		send_tick(RELEASED, 1'b0);
		send_tick(RELEASED, 1'b1);

		setup_phase(IDLE_NONE, 16'd2, 16'd12, 16'd8, 16'd3, 16'd1, 1'b0);
		press_sequences(150);
		setup_phase(IDLE_SENDER, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
		press_sequences(150);
		setup_phase(IDLE_RECEIVER, 16'd5, 16'd20, 16'd0, 16'd0, 16'd1, 1'b0);
		press_sequences(150);

		// Repeat on every tick of a long hold drives the press count into saturation.
		setup_phase(IDLE_BOTH, 16'd0, 16'd40, 16'd0, 16'd0, 16'd1, 1'b0);
		repeat (270) send_tick(PRESSED, 1'b0);
		send_tick(PRESSED, 1'b1);
		press_sequences(19);

		for (int k = 0; k < 4; k++) begin
			setup_phase(idle_mode_t'(k), cfg_word_t'($urandom_range(0, 6)),
			            cfg_word_t'($urandom_range(0, 30)),
			            cfg_word_t'($urandom_range(0, 20)),
			            cfg_word_t'($urandom_range(0, 8)),
			            cfg_word_t'($urandom_range(0, 65535)), 1'b0);
			press_sequences(75);
		end

		// With the debounce time at the timer maximum no level change is accepted.
		setup_phase(IDLE_NONE, 16'hFFFF, 16'hFFFF, 16'd750, 16'd150, 16'd0, 1'b0);
		repeat (10) send_tick(PRESSED, 1'b0);
		send_tick(PRESSED, 1'b1);

		settle();
		$display("Covered %0d ticks over %0d phases with %0d register writes.",
		         ticks_sent, phases, reg_writes);
		$display("Compared %0d results, %0d mismatches, %0d still outstanding.",
		         board.checked, board.errors, board.waiting());
		if (board.errors == 0 && board.waiting() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
